[design/scan_cylinder_detector_macros.svh]
// assertion macros for the scan cylinder detector
`ifndef SCAN_CYLINDER_DETECTOR_MACROS_SVH
`define SCAN_CYLINDER_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCD_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during reset
`define SCD_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("%m: check failed");

`endif

[design/scd_pkg.sv]
package scd_pkg;

	localparam int MAX_RAYS_DEF   = 1024;
	localparam int DEPTH_BITS_DEF = 14;
	localparam int FRAC_BITS_DEF  = 4;

	localparam int MEAN_RAY_W   = 15;
	localparam int MEAN_DEPTH_W = 18;

	localparam int MIN_VALID_RESET  = 20;
	localparam int DEPTH_JUMP_RESET = 100;

	// register indexes of the write port
	typedef enum logic [0:0] {
		REG_MIN_VALID  = 1'b0,
		REG_DEPTH_JUMP = 1'b1
	} cfg_reg_t;

	// result kinds
	localparam logic KIND_CYLINDER = 1'b0;
	localparam logic KIND_MARKER   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUT_CYL,
		ST_PUT_MARK
	} state_t;

endpackage

[design/scd_if.sv]
interface scd_item_if #(
	parameter int DEPTH_BITS = scd_pkg::DEPTH_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [DEPTH_BITS-1:0] depth;
	logic                  scan_end;

	modport source (output valid, output depth, output scan_end, input ready);
	modport sink   (input valid, input depth, input scan_end, output ready);
endinterface

interface scd_result_if;
	import scd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [MEAN_RAY_W-1:0]   mean_ray;
	logic [MEAN_DEPTH_W-1:0] mean_depth;
	logic                    last;

	modport source (output valid, output kind, output mean_ray, output mean_depth,
		output last, input ready);
	modport sink   (input valid, input kind, input mean_ray, input mean_depth,
		input last, output ready);
endinterface

[design/scan_cylinder_detector.sv]
// scan cylinder detector
//
// samples (sink): one range sample per beat, depth plus scan_end on the final
//   sample of a scan. the block judges each sample one beat late, so a
//   cylinder's falling edge, body and rising edge are seen as the scan streams in
// results (source): cylinder beats (kind 0) carry mean ray number and mean
//   depth with FRAC_BITS fractional bits, truncated; every scan closes with a
//   marker beat (kind 1, means zero). last marks the final beat caused by
//   one sample
// wr_en / wr_index / wr_data: register writes, taken on a rising clock edge with wr_en high
//
// timing: a sample that emits nothing leaves the block idle and ready for
// the next; one that only ends a scan goes through ST_PUT_MARK to load its
// marker. a sample that closes a cylinder runs the shared restoring divider,
// one quotient bit per cycle for both means; the cylinder beat is loaded when
// the divider is done and the output register is free, and no new sample is
// taken before that or before a following scan-end marker is loaded. the
// divider loop sets the throughput. results hold in the output register while
// the receiver stalls; a new sample is still taken while a marker waits there
// reset (arst_n low) restores the register defaults and clears all scan state
module scan_cylinder_detector #(
	parameter int MAX_RAYS   = scd_pkg::MAX_RAYS_DEF,
	parameter int DEPTH_BITS = scd_pkg::DEPTH_BITS_DEF,
	parameter int FRAC_BITS  = scd_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	scd_item_if.sink              samples,
	scd_result_if.source          results,
	input  logic                  wr_en,
	input  scd_pkg::cfg_reg_t     wr_index,
	input  logic [DEPTH_BITS-1:0] wr_data
);
	import scd_pkg::*;

	`include "scan_cylinder_detector_macros.svh"

	// widths: sample index, sums, signed slope, divider word
	localparam int IDX_W  = $clog2(MAX_RAYS);
	localparam int RSUM_W = 2 * IDX_W;
	localparam int DSUM_W = DEPTH_BITS + IDX_W;
	localparam int SW     = DEPTH_BITS + 3;
	localparam int QW_A   = (RSUM_W > DSUM_W ? RSUM_W : DSUM_W) + FRAC_BITS;
	localparam int QW     = QW_A > MEAN_DEPTH_W ? QW_A : MEAN_DEPTH_W;
	localparam int STEP_W = $clog2(QW);

	// configuration
	logic [DEPTH_BITS-1:0] min_valid_q;
	logic [DEPTH_BITS-1:0] jump_q;

	// scan state
	logic [DEPTH_BITS-1:0] prev_q;
	logic [DEPTH_BITS-1:0] center_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  in_cyl_q;
	logic [RSUM_W-1:0]     ray_sum_q;
	logic [DSUM_W-1:0]     depth_sum_q;
	logic [IDX_W-1:0]      ray_count_q;
	logic [DEPTH_BITS:0]   entry_q;

	// divider
	logic [QW-1:0]     num_ray_q;
	logic [QW-1:0]     num_dep_q;
	logic [IDX_W-1:0]  rem_ray_q;
	logic [IDX_W-1:0]  rem_dep_q;
	logic [IDX_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;

	// control
	state_t state_q, state_d;
	logic   mark_pend_q;
	logic   last_cyl_q;

	// output register
	logic                    out_valid_q;
	logic                    out_kind_q;
	logic [MEAN_RAY_W-1:0]   out_ray_q;
	logic [MEAN_DEPTH_W-1:0] out_dep_q;
	logic                    out_last_q;

	logic in_ready, div_run, load_cyl, load_mark;
	logic accept, out_free;

	assign accept   = samples.valid && in_ready;
	assign out_free = !out_valid_q || results.ready;

	// ---- configuration writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_q <= DEPTH_BITS'(MIN_VALID_RESET);
			jump_q      <= DEPTH_BITS'(DEPTH_JUMP_RESET);
		end else if (wr_en) begin
			case (wr_index)
				REG_MIN_VALID:  min_valid_q <= wr_data;
				REG_DEPTH_JUMP: jump_q      <= wr_data;
				default: ;
			endcase
		end
	end

	// ---- judge the center sample ----
	logic                  end_eff;
	logic                  judge_en;
	logic                  d_valid;
	logic signed [SW-1:0]  d2_w, j2_w, ent_w;
	logic [DEPTH_BITS-1:0] jump_eff;
	logic                  start_c, acc_c, emit_c;

	always_comb begin
		// overlong scan closes as if scan_end were set
		end_eff  = samples.scan_end || (idx_q == IDX_W'(MAX_RAYS - 1));
		judge_en = idx_q != '0;
		// first sample of a scan and samples next to short ranges get slope zero
		d_valid  = (idx_q != IDX_W'(1)) && (prev_q > min_valid_q) &&
			(samples.depth > min_valid_q);
		d2_w     = d_valid ? ($signed({3'b000, samples.depth}) - $signed({3'b000, prev_q}))
			: '0;
		jump_eff = (jump_q == '0) ? DEPTH_BITS'(1) : jump_q;
		j2_w     = $signed({2'b00, jump_eff, 1'b0});
		ent_w    = $signed({{2{entry_q[DEPTH_BITS]}}, entry_q});
		start_c  = (!in_cyl_q && (d2_w <= -j2_w)) || (in_cyl_q && (d2_w < ent_w));
		acc_c    = in_cyl_q && !start_c && (d2_w < j2_w);
		emit_c   = judge_en && in_cyl_q && !start_c && !acc_c;
	end

	// ---- scan state ----
	// the judge of the final sample itself can only add to the sums, and the
	// scan clears right after, so it leaves no trace
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			center_q    <= '0;
			idx_q       <= '0;
			in_cyl_q    <= 1'b0;
			ray_sum_q   <= '0;
			depth_sum_q <= '0;
			ray_count_q <= '0;
			entry_q     <= '0;
		end else if (accept) begin
			if (end_eff) begin
				prev_q      <= '0;
				center_q    <= '0;
				idx_q       <= '0;
				in_cyl_q    <= 1'b0;
				ray_sum_q   <= '0;
				depth_sum_q <= '0;
				ray_count_q <= '0;
				entry_q     <= '0;
			end else begin
				prev_q   <= center_q;
				center_q <= samples.depth;
				idx_q    <= idx_q + IDX_W'(1);
				if (judge_en && start_c) begin
					in_cyl_q    <= 1'b1;
					ray_sum_q   <= RSUM_W'(idx_q);
					depth_sum_q <= DSUM_W'(center_q);
					ray_count_q <= IDX_W'(1);
					entry_q     <= d2_w[DEPTH_BITS:0];
				end else if (judge_en && acc_c) begin
					ray_sum_q   <= ray_sum_q + RSUM_W'(idx_q);
					depth_sum_q <= depth_sum_q + DSUM_W'(center_q);
					ray_count_q <= ray_count_q + IDX_W'(1);
				end else if (emit_c) begin
					in_cyl_q <= 1'b0;
				end
			end
		end
	end

	// ---- shared restoring divider, one quotient bit per cycle ----
	logic [IDX_W:0] sh_ray, sh_dep, sub_ray, sub_dep;
	logic           q_ray, q_dep;

	always_comb begin
		sh_ray  = {rem_ray_q, num_ray_q[QW-1]};
		sh_dep  = {rem_dep_q, num_dep_q[QW-1]};
		sub_ray = sh_ray - {1'b0, den_q};
		sub_dep = sh_dep - {1'b0, den_q};
		q_ray   = sh_ray >= {1'b0, den_q};
		q_dep   = sh_dep >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (accept && emit_c) begin
			num_ray_q <= QW'(ray_sum_q) << FRAC_BITS;
			num_dep_q <= QW'(depth_sum_q) << FRAC_BITS;
			rem_ray_q <= '0;
			rem_dep_q <= '0;
			den_q     <= (ray_count_q == '0) ? IDX_W'(1) : ray_count_q;
		end else if (div_run) begin
			num_ray_q <= {num_ray_q[QW-2:0], q_ray};
			num_dep_q <= {num_dep_q[QW-2:0], q_dep};
			rem_ray_q <= q_ray ? sub_ray[IDX_W-1:0] : sh_ray[IDX_W-1:0];
			rem_dep_q <= q_dep ? sub_dep[IDX_W-1:0] : sh_dep[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (accept) begin
			step_q <= '0;
		end else if (div_run) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mark_pend_q <= 1'b0;
			last_cyl_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mark_pend_q <= end_eff;
				last_cyl_q  <= !end_eff;
			end else if (load_mark) begin
				mark_pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && emit_c) begin
					state_d = ST_DIV;
				end else if (accept && end_eff) begin
					state_d = ST_PUT_MARK;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(QW - 1)) begin
					state_d = ST_PUT_CYL;
				end
			end
			ST_PUT_CYL: begin
				if (out_free) begin
					state_d = mark_pend_q ? ST_PUT_MARK : ST_IDLE;
				end
			end
			ST_PUT_MARK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_run   = 1'b0;
		load_cyl  = 1'b0;
		load_mark = 1'b0;
		case (state_q)
			ST_IDLE:     in_ready  = 1'b1;
			ST_DIV:      div_run   = 1'b1;
			ST_PUT_CYL:  load_cyl  = out_free;
			ST_PUT_MARK: load_mark = out_free;
			default: ;
		endcase
	end

	assign samples.ready = in_ready;

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_cyl || load_mark) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cyl) begin
			out_kind_q <= KIND_CYLINDER;
			out_ray_q  <= num_ray_q[MEAN_RAY_W-1:0];
			out_dep_q  <= num_dep_q[MEAN_DEPTH_W-1:0];
			out_last_q <= last_cyl_q;
		end else if (load_mark) begin
			out_kind_q <= KIND_MARKER;
			out_ray_q  <= '0;
			out_dep_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.kind       = out_kind_q;
	assign results.mean_ray   = out_ray_q;
	assign results.mean_depth = out_dep_q;
	assign results.last       = out_last_q;

	// ---- checks ----
	`SCD_ASSERT_NOW(a_div_den_nonzero, state_q == ST_DIV, den_q != '0)
	`SCD_ASSERT_NOW(a_div_rem_bound, state_q == ST_DIV,
		(rem_ray_q < den_q) && (rem_dep_q < den_q))
	`SCD_ASSERT_NOW(a_cyl_count, in_cyl_q, (ray_count_q != '0) && (ray_count_q <= idx_q))
	`SCD_ASSERT_NEXT(a_end_marks, accept && end_eff, mark_pend_q)

endmodule

[tb/scan_cylinder_check.sv]
module scan_cylinder_check (
	input  logic                               clk,
	input  logic                               arst_n,
	scd_item_if                                samples,
	scd_result_if                              results,
	input  logic                               wr_en,
	input  scd_pkg::cfg_reg_t                  wr_index,
	input  logic [scd_pkg::DEPTH_BITS_DEF-1:0] wr_data,
	output int                                 mismatches,
	output int                                 pending
);
	import scd_pkg::*;

	localparam int DW = DEPTH_BITS_DEF;

	typedef struct packed {
		logic                    kind;
		logic [MEAN_RAY_W-1:0]   mean_ray;
		logic [MEAN_DEPTH_W-1:0] mean_depth;
		logic                    last;
	} scan_result_t;

	scan_result_t expected_q[$];

	// register copies
	logic [DW-1:0] min_valid;
	logic [DW-1:0] jump_reg;

	// scan state
	logic [DW-1:0]      prev_depth;
	logic [DW-1:0]      center_depth;
	logic [10:0]        ray_index;
	logic               in_cyl;
	logic [19:0]        ray_acc;
	logic [23:0]        depth_acc;
	logic [10:0]        ray_cnt;
	logic signed [15:0] entry_slope;

	function automatic void clear_scan();
		prev_depth   = '0;
		center_depth = '0;
		ray_index    = '0;
		in_cyl       = 1'b0;
		ray_acc      = '0;
		depth_acc    = '0;
		ray_cnt      = '0;
		entry_slope  = '0;
	endfunction

	// one sample with its ray number and doubled derivative; 1 when a cylinder closes
	function automatic bit judge_sample(input int ray, input logic [DW-1:0] dep,
		input int d2, output scan_result_t cyl);
		int     j2;
		longint n;
		j2  = 2 * ((jump_reg == '0) ? 1 : int'(jump_reg));
		cyl = '0;
		if ((!in_cyl && d2 <= -j2) || (in_cyl && d2 < int'(entry_slope))) begin
			in_cyl      = 1'b1;
			ray_acc     = 20'(ray);
			depth_acc   = 24'(dep);
			ray_cnt     = 11'd1;
			entry_slope = 16'(d2);
		end else if (in_cyl && d2 < j2) begin
			ray_acc   = ray_acc + 20'(ray);
			depth_acc = depth_acc + 24'(dep);
			ray_cnt   = ray_cnt + 11'd1;
		end else if (in_cyl) begin
			n              = (ray_cnt == '0) ? longint'(1) : longint'(ray_cnt);
			cyl.kind       = KIND_CYLINDER;
			cyl.mean_ray   = MEAN_RAY_W'((longint'(ray_acc) << FRAC_BITS_DEF) / n);
			cyl.mean_depth = MEAN_DEPTH_W'((longint'(depth_acc) << FRAC_BITS_DEF) / n);
			in_cyl         = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_sample(input logic [DW-1:0] dep, input logic scan_last);
		scan_result_t burst[3];
		scan_result_t cyl;
		int           c;
		int           d2;
		int           n;
		logic         closing;
		c       = int'(ray_index);
		closing = scan_last || (c + 1 >= MAX_RAYS_DEF);
		n       = 0;
		// the center sample is judged now that its right neighbor is here
		if (c >= 1) begin
			d2 = 0;
			if (c != 1 && prev_depth > min_valid && dep > min_valid)
				d2 = int'(dep) - int'(prev_depth);
			if (judge_sample(c, center_depth, d2, cyl)) begin
				burst[n] = cyl;
				n++;
			end
		end
		prev_depth   = center_depth;
		center_depth = dep;
		ray_index    = 11'(c + 1);
		if (closing) begin
			if (judge_sample(c + 1, dep, 0, cyl)) begin
				burst[n] = cyl;
				n++;
			end
			burst[n]      = '0;
			burst[n].kind = KIND_MARKER;
			n++;
			clear_scan();
		end
		if (n > 0)
			burst[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_q.insert(expected_q.size(), burst[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		scan_result_t want;
		if (!arst_n) begin
			min_valid = DW'(MIN_VALID_RESET);
			jump_reg  = DW'(DEPTH_JUMP_RESET);
			clear_scan();
			expected_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result kind %0d ray %0d depth %0d last %0d",
						$time, results.kind, results.mean_ray, results.mean_depth,
						results.last);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (results.kind !== want.kind || results.mean_ray !== want.mean_ray ||
						results.mean_depth !== want.mean_depth ||
						results.last !== want.last) begin
						$display("%0t: kind/ray/depth/last expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							$time, want.kind, want.mean_ray, want.mean_depth, want.last,
							results.kind, results.mean_ray, results.mean_depth,
							results.last);
						mismatches++;
					end
				end
			end
			if (samples.valid && samples.ready)
				predict_sample(samples.depth, samples.scan_end);
			if (wr_en) begin
				case (wr_index)
					REG_MIN_VALID:  min_valid = wr_data;
					REG_DEPTH_JUMP: jump_reg = wr_data;
					default: ;
				endcase
			end
			pending <= expected_q.size();
		end
	end

endmodule

[tb/scan_cylinder_detector_tb.sv]
module scan_cylinder_detector_tb;
	import scd_pkg::*;

	localparam int DW          = DEPTH_BITS_DEF;
	localparam int DEPTH_MAX   = (1 << DW) - 1;
	localparam int LIMIT_CYCLES = 1000000;
	// settle time for the divider, which a closing sample keeps busy
	localparam int SETTLE_CYCLES = 40;
	localparam int TOUR_LEN      = 26;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          wr_en;
	cfg_reg_t      wr_index;
	logic [DW-1:0] wr_data;

	scd_item_if   samples ();
	scd_result_if results ();

	int mismatches;
	int pending;
	int cycles = 0;
	int sent = 0;

	// idling knobs of the current phase, in percent
	int send_idle_pct;
	int recv_stall_pct;

	// register values the scene generator shapes its scans for
	int cur_mvd;
	int cur_jump;

	// directed tour: single-sample scans at both extremes, a plain cylinder,
	// a cylinder re-entered on a steeper falling edge, a neighbor right at the
	// validity distance, and a rising edge on the final sample (cylinder + marker)
	int tour_depth [TOUR_LEN] = '{
		16383, 0,
		1000, 1000, 500, 500, 500, 1000, 1000,
		2000, 2000, 1500, 1500, 800, 800, 800, 2000, 2000,
		1000, 1000, 20, 16383,
		1000, 400, 400, 1000
	};
	bit tour_last [TOUR_LEN] = '{
		1, 1,
		0, 0, 0, 0, 0, 0, 1,
		0, 0, 0, 0, 0, 0, 0, 0, 1,
		0, 0, 0, 1,
		0, 0, 0, 1
	};

	always #10 clk = ~clk;

	scan_cylinder_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	scan_cylinder_check cyl_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.results    (results),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver side: random back-pressure on the result channel
	always @(posedge clk) begin
		results.ready <= arst_n && ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("scan_cylinder_detector_tb: errors");
			$finish;
		end
	end

	function automatic logic [DW-1:0] clamp_depth(input int v);
		if (v < 0)
			return '0;
		if (v > DEPTH_MAX)
			return '1;
		return v[DW-1:0];
	endfunction

	// one sample beat, after a random gap; valid stays high on return
	task automatic send_sample(input logic [DW-1:0] d, input logic scan_last);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid    <= 1'b1;
		samples.depth    <= d;
		samples.scan_end <= scan_last;
		do @(posedge clk); while (!samples.ready);
		sent++;
	endtask

	// stop sending, wait for every expected beat, then let the divider go quiet
	task automatic drain_results();
		samples.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v[DW-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// one scan: a wall with noise, cylinders dropping in front of it by more
	// than the jump, now and then a steeper step inside a cylinder, samples
	// at or below the validity distance and random outliers; some scans are
	// pure noise over the whole depth range
	task automatic send_scan(input int len);
		int jmp;
		int lo;
		int wall;
		int body;
		int body_left;
		int v;
		int r;
		int noise;
		bit garbage;
		jmp = (cur_jump == 0) ? 1 : cur_jump;
		lo  = cur_mvd + 4 * jmp + 1;
		if (lo > 16000)
			lo = 16000;
		wall      = int'($urandom_range(DEPTH_MAX, lo));
		body      = wall;
		body_left = 0;
		garbage   = ($urandom_range(11, 0) == 0);
		for (int pos = 0; pos < len; pos++) begin
			r     = int'($urandom_range(99, 0));
			noise = int'($urandom_range(jmp / 2, 0)) - jmp / 4;
			if (garbage) begin
				v = int'($urandom_range(DEPTH_MAX, 0));
			end else if (body_left > 0) begin
				body_left--;
				// steeper falling edge restarts the cylinder
				if (r < 8)
					body = body - 2 * jmp - int'($urandom_range(jmp, 0));
				v = body + noise;
			end else if (r < 15) begin
				body_left = int'($urandom_range(9, 0));
				body      = wall - 2 * jmp - int'($urandom_range(2 * jmp, 0));
				v         = body + noise;
			end else if (r < 19) begin
				v = int'($urandom_range(DEPTH_MAX, 0));
			end else if (r < 21) begin
				v = int'($urandom_range(cur_mvd, 0));
			end else begin
				v = wall + noise;
			end
			send_sample(clamp_depth(v), pos == len - 1);
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int mvd,
		input int jump, input int budget);
		int goal;
		drain_results();
		write_reg(REG_MIN_VALID, mvd);
		write_reg(REG_DEPTH_JUMP, jump);
		cur_mvd        = mvd;
		cur_jump       = jump;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		goal           = sent + budget;
		while (sent < goal) begin
			if ($urandom_range(7, 0) == 0)
				send_scan(int'($urandom_range(3, 1)));
			else
				send_scan(int'($urandom_range(80, 4)));
			// occasional full drain with the sender held off
			if ($urandom_range(14, 0) == 0)
				drain_results();
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = REG_MIN_VALID;
		wr_data          = '0;
		samples.valid    = 1'b0;
		samples.depth    = '0;
		samples.scan_end = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		cur_mvd          = MIN_VALID_RESET;
		cur_jump         = DEPTH_JUMP_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed tour at the reset register values
		for (int i = 0; i < TOUR_LEN; i++)
			send_sample(tour_depth[i][DW-1:0], tour_last[i]);

		// smallest thresholds, no idling, then a scan past MAX_RAYS without a
		// scan end until its very last sample
		run_phase(0, 0, 0, 1, 20);
		send_scan(1030);

		// sender mostly idle, moderate thresholds
		run_phase(83, 0, int'($urandom_range(2000, 0)), int'($urandom_range(800, 20)), 30);

		// largest thresholds: derivatives vanish, only markers come out
		run_phase(0, 83, DEPTH_MAX, DEPTH_MAX, 20);

		// zero jump behaves as one
		run_phase(0, 83, 0, 0, 20);

		// receiver mostly stalled, cylinders plentiful
		run_phase(0, 83, 30, 150, 30);

		// both sides idling now and then, reset values written back
		run_phase(27, 27, MIN_VALID_RESET, DEPTH_JUMP_RESET, 30);

		// random register values over the full width
		run_phase(0, 0, int'($urandom_range(DEPTH_MAX, 0)),
			int'($urandom_range(DEPTH_MAX, 0)), 20);

		drain_results();
		if (mismatches == 0 && pending == 0)
			$display("scan_cylinder_detector_tb: clean");
		else
			$display("scan_cylinder_detector_tb: errors");
		$finish;
	end

endmodule
